### rtl/core/ddgc_pkg.sv
// ----------------------------------------------------------------------------
// ddgc_pkg
// Shared types, constants and helper functions of the go-to-pose controller.
// ----------------------------------------------------------------------------
package ddgc_pkg;

    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 56;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_GAIN_DIST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_GAIN_DRIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_GAIN_DRIVE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRANSLATION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DISTANCE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_TOL      = 3'd6;

    // register reset values
    localparam logic [15:0] RST_TRANS_GAIN_DIST  = 16'd5120;
    localparam logic [15:0] RST_TRANS_GAIN_DRIVE = 16'd2560;
    localparam logic [15:0] RST_ROT_GAIN_DRIVE   = 16'd51200;
    localparam logic [15:0] RST_ACCEL_STEP       = 16'd26;
    localparam logic [15:0] RST_MAX_TRANSLATION  = 16'd65280;
    localparam logic [14:0] RST_ARRIVE_DISTANCE  = 15'd41;
    localparam logic [14:0] RST_HEADING_TOL      = 15'd492;

    // angles: 1/8192 rad; CORDIC angle accumulator: 1/65536 rad
    localparam logic signed [17:0] PI_Q      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q  = 18'sd51472;
    localparam logic signed [19:0] HALF_PI_Z = 20'sd102944;

    localparam int unsigned CORDIC_ITERS = 16;

    localparam logic [1:0] PHASE_TURNING = 2'd0;
    localparam logic [1:0] PHASE_DRIVING = 2'd1;
    localparam logic [1:0] PHASE_ARRIVED = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT,
        ST_DECIDE,
        ST_MUL_TGT,
        ST_RAMP,
        ST_MUL_DRV,
        ST_DRIVE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic [7:0] pwm;
        logic       fwd;
    } wheel_t;

    function automatic logic [19:0] atan_lut(input logic [3:0] idx);
        logic [19:0] v;
        case (idx)
            4'd0:    v = 20'd51472;
            4'd1:    v = 20'd30386;
            4'd2:    v = 20'd16055;
            4'd3:    v = 20'd8150;
            4'd4:    v = 20'd4091;
            4'd5:    v = 20'd2047;
            4'd6:    v = 20'd1024;
            4'd7:    v = 20'd512;
            4'd8:    v = 20'd256;
            4'd9:    v = 20'd128;
            4'd10:   v = 20'd64;
            4'd11:   v = 20'd32;
            4'd12:   v = 20'd16;
            4'd13:   v = 20'd8;
            4'd14:   v = 20'd4;
            4'd15:   v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    // |num| >> 21, capped at 255; forward when num >= 0
    function automatic wheel_t wheel_drive(input logic signed [39:0] num);
        logic [39:0] mag;
        logic [18:0] top;
        wheel_t      w;
        mag   = num[39] ? 40'(-num) : 40'(num);
        top   = mag[39:21];
        w.pwm = (|top[18:8]) ? 8'hFF : top[7:0];
        w.fwd = ~num[39];
        return w;
    endfunction

endpackage

### rtl/core/diff_drive_goto_controller.sv
// ----------------------------------------------------------------------------
// diff_drive_goto_controller
// Rotate-then-translate go-to-pose controller for a differential-drive robot.
//
//   channel  | dir | contents
//   s_axis   | in  | robot pose, goal pose; tuser = apply
//   m_axis   | out | wheel drives, phase, translation and rotation commands
//   cfg      | in  | register writes, index 0..6
//
// One request at a time: m_tvalid rises when the result is loaded, and the
// next request is taken only after that load.
// Two serial squarers run beside the CORDIC, then the square root, the
// distance gain multiply and the two wheel multiplies, plus control steps.
// Synchronous active-low reset; registers return to their defaults.
// A result held on a stalled m_axis keeps the next request waiting there.
// ----------------------------------------------------------------------------
module diff_drive_goto_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pose_x, pose_y, pose_heading, goal_x, goal_y, goal_heading
    input  logic [ddgc_pkg::IN_DATA_W-1:0]      s_tdata,
    // apply
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_pwm, left_forward, right_pwm, right_forward, motion_phase,
    // translation_cmd, zero bit, rotation_cmd, zero fill
    output logic [ddgc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [ddgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ddgc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    ddgc_pkg::state_t state_reg, state_next;

    logic [15:0] gain_dist_reg, gain_drive_reg, rot_gain_reg, accel_reg, max_reg;
    logic [14:0] arrive_reg, tol_reg;

    logic signed [15:0] ph_reg, gh_reg;
    logic               apply_reg, zero_vec_reg;
    logic [15:0]        trans_reg;
    logic [1:0]         phase_reg;
    logic signed [15:0] err_reg;
    logic [14:0]        abs_err_reg;
    logic               driving_reg;
    logic [20:0]        target_reg;
    logic [16:0]        dist_reg;
    logic [31:0]        tp_reg;
    logic [30:0]        rp_reg;
    ddgc_pkg::wheel_t   left_reg, right_reg;
    logic               m_valid_reg;
    logic [52:0]        out_reg;

    logic               accept;
    logic signed [16:0] dx, dy, px, py, gx, gy;
    logic [15:0]        adx, ady;

    logic               mul_a_start, mul_b_start, mul_a_done, mul_b_done;
    logic [16:0]        mul_a_mcand, mul_b_mcand;
    logic [15:0]        mul_a_mplier, mul_b_mplier;
    logic [32:0]        mul_a_prod, mul_b_prod;
    logic               sqrt_start, sqrt_done;
    logic [16:0]        sqrt_root;
    logic signed [16:0] bearing;

    logic               arrived;
    logic signed [17:0] ang_tgt, err_raw, err_wrap, err_abs;
    logic [16:0]        ramp_up, ramp_val, trans_sum;
    logic [15:0]        trans_next;
    logic signed [39:0] tp40, rp40, num_l, num_r;
    logic               out_load;

    assign accept = s_tvalid && s_tready;
    assign px = {s_tdata[15], s_tdata[15:0]};
    assign py = {s_tdata[31], s_tdata[31:16]};
    assign gx = {s_tdata[63], s_tdata[63:48]};
    assign gy = {s_tdata[79], s_tdata[79:64]};
    assign dx = gx - px;
    assign dy = gy - py;
    assign adx = dx[16] ? 16'(-dx) : dx[15:0];
    assign ady = dy[16] ? 16'(-dy) : dy[15:0];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_dist_reg  <= ddgc_pkg::RST_TRANS_GAIN_DIST;
            gain_drive_reg <= ddgc_pkg::RST_TRANS_GAIN_DRIVE;
            rot_gain_reg   <= ddgc_pkg::RST_ROT_GAIN_DRIVE;
            accel_reg      <= ddgc_pkg::RST_ACCEL_STEP;
            max_reg        <= ddgc_pkg::RST_MAX_TRANSLATION;
            arrive_reg     <= ddgc_pkg::RST_ARRIVE_DISTANCE;
            tol_reg        <= ddgc_pkg::RST_HEADING_TOL;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ddgc_pkg::REG_TRANS_GAIN_DIST:  gain_dist_reg  <= cfg_wdata;
                ddgc_pkg::REG_TRANS_GAIN_DRIVE: gain_drive_reg <= cfg_wdata;
                ddgc_pkg::REG_ROT_GAIN_DRIVE:   rot_gain_reg   <= cfg_wdata;
                ddgc_pkg::REG_ACCEL_STEP:       accel_reg      <= cfg_wdata;
                ddgc_pkg::REG_MAX_TRANSLATION:  max_reg        <= cfg_wdata;
                ddgc_pkg::REG_ARRIVE_DISTANCE:  arrive_reg     <= cfg_wdata[14:0];
                ddgc_pkg::REG_HEADING_TOL:      tol_reg        <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    ddgc_mul u_mul_a (
        .aclk(aclk), .aresetn(aresetn), .start(mul_a_start),
        .mcand(mul_a_mcand), .mplier(mul_a_mplier),
        .done(mul_a_done), .prod(mul_a_prod)
    );

    ddgc_mul u_mul_b (
        .aclk(aclk), .aresetn(aresetn), .start(mul_b_start),
        .mcand(mul_b_mcand), .mplier(mul_b_mplier),
        .done(mul_b_done), .prod(mul_b_prod)
    );

    ddgc_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .radicand({2'b00, mul_a_prod[31:0]} + {2'b00, mul_b_prod[31:0]}),
        .done(sqrt_done), .root(sqrt_root)
    );

    ddgc_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(accept),
        .dx(dx), .dy(dy), .bearing(bearing)
    );

    // phase and heading error
    always_comb begin
        arrived = {2'b00, arrive_reg} > dist_reg;
        if (arrived) begin
            ang_tgt = {{2{gh_reg[15]}}, gh_reg};
        end else if (zero_vec_reg) begin
            ang_tgt = '0;
        end else begin
            ang_tgt = {bearing[16], bearing};
        end
        err_raw = ang_tgt - {{2{ph_reg[15]}}, ph_reg};
        if (err_raw > ddgc_pkg::PI_Q) begin
            err_wrap = err_raw - ddgc_pkg::TWO_PI_Q;
        end else if (err_raw < -ddgc_pkg::PI_Q) begin
            err_wrap = err_raw + ddgc_pkg::TWO_PI_Q;
        end else begin
            err_wrap = err_raw;
        end
        err_abs = err_wrap[17] ? -err_wrap : err_wrap;
    end

    // translation ramp and clamp
    always_comb begin
        ramp_up   = {1'b0, trans_reg} + {1'b0, accel_reg};
        trans_sum = {1'b0, trans_reg};
        if ({5'd0, trans_reg} > target_reg) begin
            ramp_val = target_reg[16:0];
        end else if ({5'd0, trans_reg} < target_reg) begin
            ramp_val = ramp_up;
        end else begin
            ramp_val = trans_sum;
        end
        trans_next = (ramp_val > {1'b0, max_reg}) ? max_reg : ramp_val[15:0];
    end

    // wheel drive sums
    always_comb begin
        tp40  = signed'({3'd0, tp_reg, 5'd0});
        rp40  = err_reg[15] ? -signed'({9'd0, rp_reg}) : signed'({9'd0, rp_reg});
        num_l = tp40 - rp40;
        num_r = tp40 + rp40;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ddgc_pkg::ST_IDLE:    if (accept) state_next = ddgc_pkg::ST_SQUARE;
            ddgc_pkg::ST_SQUARE:  if (mul_a_done && mul_b_done) state_next = ddgc_pkg::ST_SQRT;
            ddgc_pkg::ST_SQRT:    if (sqrt_done) state_next = ddgc_pkg::ST_DECIDE;
            ddgc_pkg::ST_DECIDE:  state_next = ddgc_pkg::ST_MUL_TGT;
            ddgc_pkg::ST_MUL_TGT: if (mul_a_done) state_next = ddgc_pkg::ST_RAMP;
            ddgc_pkg::ST_RAMP:    state_next = ddgc_pkg::ST_MUL_DRV;
            ddgc_pkg::ST_MUL_DRV: if (mul_a_done) state_next = ddgc_pkg::ST_DRIVE;
            ddgc_pkg::ST_DRIVE:   state_next = ddgc_pkg::ST_OUTPUT;
            ddgc_pkg::ST_OUTPUT:  if (out_load) state_next = ddgc_pkg::ST_IDLE;
            default:              state_next = ddgc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready     = 1'b0;
        mul_a_start  = 1'b0;
        mul_b_start  = 1'b0;
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        mul_a_mcand  = {1'b0, adx};
        mul_a_mplier = adx;
        mul_b_mcand  = {1'b0, ady};
        mul_b_mplier = ady;
        case (state_reg)
            ddgc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                mul_a_start = s_tvalid;
                mul_b_start = s_tvalid;
            end
            ddgc_pkg::ST_SQUARE: begin
                sqrt_start = mul_a_done && mul_b_done;
            end
            ddgc_pkg::ST_DECIDE: begin
                mul_a_start  = 1'b1;
                mul_a_mcand  = dist_reg;
                mul_a_mplier = gain_dist_reg;
            end
            ddgc_pkg::ST_RAMP: begin
                mul_a_start  = 1'b1;
                mul_a_mcand  = {1'b0, trans_next};
                mul_a_mplier = gain_drive_reg;
                mul_b_start  = 1'b1;
                mul_b_mcand  = {2'b00, abs_err_reg};
                mul_b_mplier = rot_gain_reg;
            end
            ddgc_pkg::ST_OUTPUT: begin
                out_load = !m_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ddgc_pkg::ST_IDLE;
            trans_reg   <= '0;
            phase_reg   <= ddgc_pkg::PHASE_TURNING;
            left_reg    <= '{pwm: 8'd0, fwd: 1'b1};
            right_reg   <= '{pwm: 8'd0, fwd: 1'b1};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ddgc_pkg::ST_DECIDE) begin
                if (arrived) begin
                    phase_reg <= ddgc_pkg::PHASE_ARRIVED;
                end else if (err_abs > {3'd0, tol_reg}) begin
                    phase_reg <= ddgc_pkg::PHASE_TURNING;
                end else begin
                    phase_reg <= ddgc_pkg::PHASE_DRIVING;
                end
            end
            if (state_reg == ddgc_pkg::ST_RAMP) begin
                trans_reg <= trans_next;
            end
            if (state_reg == ddgc_pkg::ST_DRIVE && apply_reg) begin
                left_reg  <= ddgc_pkg::wheel_drive(num_l);
                right_reg <= ddgc_pkg::wheel_drive(num_r);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request payload and intermediate results
    always_ff @(posedge aclk) begin
        if (accept) begin
            ph_reg       <= s_tdata[47:32];
            gh_reg       <= s_tdata[95:80];
            apply_reg    <= s_tuser;
            zero_vec_reg <= (dx == 17'sd0) && (dy == 17'sd0);
        end
        if (sqrt_done) begin
            dist_reg <= sqrt_root;
        end
        if (state_reg == ddgc_pkg::ST_DECIDE) begin
            err_reg     <= err_wrap[15:0];
            abs_err_reg <= err_abs[14:0];
            driving_reg <= !arrived && !(err_abs > {3'd0, tol_reg});
        end
        if (state_reg == ddgc_pkg::ST_MUL_TGT && mul_a_done) begin
            target_reg <= driving_reg ? mul_a_prod[32:12] : 21'd0;
        end
        if (state_reg == ddgc_pkg::ST_MUL_DRV && mul_a_done) begin
            tp_reg <= mul_a_prod[31:0];
            rp_reg <= mul_b_prod[30:0];
        end
        if (out_load) begin
            out_reg <= {err_reg, 1'b0, trans_reg, phase_reg,
                        right_reg.fwd, right_reg.pwm, left_reg.fwd, left_reg.pwm};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, out_reg};

endmodule

### rtl/core/ddgc_mul.sv
// ----------------------------------------------------------------------------
// ddgc_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddgc_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] mcand,
    input  logic [15:0] mplier,
    output logic        done,
    output logic [32:0] prod
);

    logic [16:0] a_reg;
    logic [17:0] hi_reg, hi_next;
    logic [15:0] lo_reg, lo_next;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [17:0] sum;

    always_comb begin
        sum     = hi_reg + (lo_reg[0] ? {1'b0, a_reg} : 18'd0);
        hi_next = {1'b0, sum[17:1]};
        lo_next = {sum[0], lo_reg[15:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 4'd15);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= mcand;
            hi_reg <= '0;
            lo_reg <= mplier;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg[16:0], lo_reg};

endmodule

### rtl/core/ddgc_sqrt.sv
// ----------------------------------------------------------------------------
// ddgc_sqrt
// Digit-by-digit square root, one result bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module ddgc_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [33:0] radicand,
    output logic        done,
    output logic [16:0] root
);

    logic [34:0] rem_reg;
    logic [34:0] root_reg;
    logic [33:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [34:0] trial;
    logic        fits;

    assign trial = root_reg + {1'b0, bit_reg};
    assign fits  = rem_reg >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 5'd16);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd16) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, radicand};
            root_reg <= '0;
            bit_reg  <= 34'h1_0000_0000;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg  <= rem_reg - trial;
                root_reg <= {1'b0, root_reg[34:1]} + {1'b0, bit_reg};
            end else begin
                root_reg <= {1'b0, root_reg[34:1]};
            end
            bit_reg <= {2'b00, bit_reg[33:2]};
        end
    end

    assign done = done_reg;
    assign root = root_reg[16:0] + {16'd0, (rem_reg > root_reg)};

endmodule

### rtl/core/ddgc_cordic.sv
// ----------------------------------------------------------------------------
// ddgc_cordic
// Vectoring CORDIC for the bearing atan2(dy, dx), one iteration per cycle.
// ----------------------------------------------------------------------------
module ddgc_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [16:0] dx,
    input  logic signed [16:0] dy,
    output logic signed [16:0] bearing
);

    logic signed [27:0] x_reg, y_reg;
    logic signed [19:0] z_reg;
    logic [3:0]         i_reg;
    logic               busy_reg;
    logic signed [27:0] x0, y0, xs, ys;
    logic signed [19:0] ang, z_rnd;

    assign x0    = {{3{dx[16]}}, dx, 8'd0};
    assign y0    = {{3{dy[16]}}, dy, 8'd0};
    assign xs    = x_reg >>> i_reg;
    assign ys    = y_reg >>> i_reg;
    assign ang   = signed'(ddgc_pkg::atan_lut(i_reg));
    assign z_rnd = z_reg + 20'sd4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            i_reg    <= '0;
        end else if (busy_reg) begin
            i_reg <= i_reg + 4'd1;
            if (i_reg == 4'(ddgc_pkg::CORDIC_ITERS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            if (!dx[16]) begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end else if (!dy[16]) begin
                x_reg <= y0;
                y_reg <= -x0;
                z_reg <= ddgc_pkg::HALF_PI_Z;
            end else begin
                x_reg <= -y0;
                y_reg <= x0;
                z_reg <= -ddgc_pkg::HALF_PI_Z;
            end
        end else if (busy_reg) begin
            if (!y_reg[27]) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
        end
    end

    assign bearing = z_rnd[19:3];

endmodule
